// ===== sv/clce_pkg.sv =====
package clce_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STEP_BITS  = 31;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [VALUE_W-1:0] VALUE_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ROTATE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic    in_ready;
    logic    ins_slot;
    logic    ins_commit;
    logic    rem_fetch;
    logic    rem_commit;
    logic    div_step;
    logic    walk_step;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    op_e  op;
    logic empty;
    logic single;
    logic full;
    logic step_pos;
    logic div_done;
    logic moves_zero;
    logic out_stall;
  } stat_t;

endpackage

// ===== sv/clce_ctrl.sv =====
module clce_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clce_pkg::stat_t stat_i,
  output clce_pkg::cmd_t  cmd_o
);
  import clce_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DISP     = 11'b000_0000_0010,
    S_INS_NEW  = 11'b000_0000_0100,
    S_INS_LINK = 11'b000_0000_1000,
    S_REM_RD   = 11'b000_0001_0000,
    S_REM_LINK = 11'b000_0010_0000,
    S_ROT_DIV  = 11'b000_0100_0000,
    S_ROT_WAIT = 11'b000_1000_0000,
    S_ROT_STEP = 11'b001_0000_0000,
    S_VAL      = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.out_status = status_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          state_d  = S_DISP;
          status_d = ST_DONE;
        end
      end
      S_DISP: begin
        unique case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.full) begin
              status_d = ST_FULL;
              state_d  = S_VAL;
            end else begin
              state_d = S_INS_NEW;
            end
          end
          OP_REMOVE: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
              state_d  = S_VAL;
            end else begin
              state_d = S_REM_RD;
            end
          end
          OP_ROTATE: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
              state_d  = S_VAL;
            end else if (stat_i.step_pos) begin
              state_d = S_ROT_DIV;
            end else begin
              state_d = S_VAL;
            end
          end
          OP_NOP: state_d = S_VAL;
          default: state_d = S_VAL;
        endcase
      end
      S_INS_NEW: begin
        cmd_o.ins_slot = 1'b1;
        state_d = S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd_o.ins_commit = 1'b1;
        state_d = S_VAL;
      end
      S_REM_RD: begin
        cmd_o.rem_fetch = 1'b1;
        state_d = S_REM_LINK;
      end
      S_REM_LINK: begin
        cmd_o.rem_commit = 1'b1;
        state_d = S_VAL;
      end
      S_ROT_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_ROT_WAIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_ROT_WAIT: begin
        state_d = stat_i.moves_zero ? S_VAL : S_ROT_STEP;
      end
      S_ROT_STEP: begin
        cmd_o.walk_step = 1'b1;
        state_d = S_ROT_WAIT;
      end
      S_VAL: state_d = S_OUT;
      S_OUT: begin
        if (!stat_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

// ===== sv/clce_dp.sv =====
module clce_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  clce_pkg::cmd_t                       cmd_i,
  output clce_pkg::stat_t                      stat_o,
  input  logic                                 s_axis_tvalid_i,
  input  logic [clce_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  input  logic [clce_pkg::OP_W-1:0]            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [clce_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic [clce_pkg::STATUS_W-1:0]        m_axis_tuser_o
);
  import clce_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] val_mem  [CAPACITY];
  logic [IDX_W-1:0]   link_mem [CAPACITY];
  logic [IDX_W-1:0]   free_mem [CAPACITY];

  logic                 load_item;
  op_e                  op_q;
  logic [VALUE_W-1:0]   value_q;
  logic [VALUE_W-1:0]   steps_q;
  logic [IDX_W-1:0]     cursor_q;
  logic [CNT_W-1:0]     size_q;
  logic [CNT_W-1:0]     free_cnt_q;
  logic [CNT_W-1:0]     fresh_q;
  logic [IDX_W-1:0]     slot_q;
  logic [IDX_W-1:0]     target_q;
  logic [IDX_W-1:0]     link_rd_q;
  logic [IDX_W-1:0]     free_rd_q;
  logic [VALUE_W-1:0]   val_rd_q;
  logic [STEP_BITS-1:0] dvd_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [CNT_W-1:0]     rem_q;

  logic                 free_avail;
  logic [IDX_W-1:0]     slot_d;
  logic [CNT_W-1:0]     free_top_m1;
  logic [IDX_W-1:0]     link_raddr;
  logic                 link_we;
  logic [IDX_W-1:0]     link_waddr;
  logic [IDX_W-1:0]     link_wdata;
  logic [CNT_W:0]       rem_shift;
  logic [CNT_W:0]       rem_diff;
  logic                 size_zero;
  logic                 size_one;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [STATUS_W-1:0]  out_user_q;
  logic [VALUE_W-1:0]   shown;

  assign load_item   = cmd_i.in_ready & s_axis_tvalid_i;
  assign size_zero   = (size_q == '0);
  assign size_one    = (size_q == CNT_W'(1));
  assign free_avail  = (free_cnt_q != '0);
  assign free_top_m1 = free_cnt_q - CNT_W'(1);
  assign slot_d      = free_avail ? free_rd_q : fresh_q[IDX_W-1:0];
  assign link_raddr  = cmd_i.rem_fetch ? link_rd_q : cursor_q;
  assign rem_shift   = {rem_q, dvd_q[STEP_BITS-1]};
  assign rem_diff    = rem_shift - {1'b0, size_q};

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cursor_q;
    link_wdata = slot_q;
    priority if (cmd_i.ins_slot) begin
      link_we    = 1'b1;
      link_waddr = slot_d;
      link_wdata = size_zero ? slot_d : link_rd_q;
    end else if (cmd_i.ins_commit) begin
      link_we    = !size_zero;
      link_wdata = slot_q;
    end else if (cmd_i.rem_commit) begin
      link_we    = !size_one;
      link_wdata = link_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_slot) begin
      val_mem[slot_d] <= value_q;
    end
    val_rd_q <= val_mem[cursor_q];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rem_commit) begin
      free_mem[free_cnt_q[IDX_W-1:0]] <= target_q;
    end
    free_rd_q <= free_mem[free_top_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      op_q    <= op_e'(s_axis_tuser_i);
      value_q <= s_axis_tdata_i[VALUE_W-1:0];
      steps_q <= s_axis_tdata_i[2*VALUE_W-1:VALUE_W];
    end
    if (cmd_i.ins_slot) begin
      slot_q <= slot_d;
    end
    if (cmd_i.rem_fetch) begin
      target_q <= link_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= '0;
      size_q     <= '0;
      free_cnt_q <= '0;
      fresh_q    <= '0;
      dvd_q      <= '0;
      div_cnt_q  <= '0;
      rem_q      <= '0;
    end else begin
      if (load_item) begin
        dvd_q     <= s_axis_tdata_i[VALUE_W+STEP_BITS-1:VALUE_W];
        div_cnt_q <= DIV_CNT_W'(STEP_BITS);
        rem_q     <= '0;
      end else if (cmd_i.div_step) begin
        dvd_q     <= {dvd_q[STEP_BITS-2:0], 1'b0};
        div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
        rem_q     <= rem_diff[CNT_W] ? rem_shift[CNT_W-1:0] : rem_diff[CNT_W-1:0];
      end else if (cmd_i.walk_step) begin
        rem_q    <= rem_q - CNT_W'(1);
        cursor_q <= link_rd_q;
      end
      if (cmd_i.ins_commit) begin
        cursor_q <= slot_q;
        size_q   <= size_q + CNT_W'(1);
        if (free_avail) begin
          free_cnt_q <= free_top_m1;
        end else begin
          fresh_q <= fresh_q + CNT_W'(1);
        end
      end
      if (cmd_i.rem_commit) begin
        size_q     <= size_q - CNT_W'(1);
        free_cnt_q <= free_cnt_q + CNT_W'(1);
        if (size_one) begin
          cursor_q <= '0;
        end
      end
    end
  end

  assign shown = size_zero ? VALUE_NONE : val_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_user_q <= cmd_i.out_status;
      out_data_q <= {(OUT_DATA_W - VALUE_W - COUNT_W - 1)'(0), size_zero,
                     COUNT_W'(size_q), shown};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  always_comb begin
    stat_o            = '0;
    stat_o.in_valid   = s_axis_tvalid_i;
    stat_o.op         = op_q;
    stat_o.empty      = size_zero;
    stat_o.single     = size_one;
    stat_o.full       = (size_q == CNT_W'(CAPACITY));
    stat_o.step_pos   = !steps_q[VALUE_W-1] && (steps_q != '0);
    stat_o.div_done   = (div_cnt_q == '0);
    stat_o.moves_zero = (rem_q == '0);
    stat_o.out_stall  = out_valid_q && !m_axis_tready_i;
  end

endmodule

// ===== sv/circular_list_cursor_engine.sv =====
// channel   dir  tdata                                      tuser
// s_axis    in   [31:0] data_value, [63:32] step_count      [1:0] op
// m_axis    out  [31:0] cursor_value, [36:32] node_count,   [1:0] status
//                [37] is_empty, [39:38] zero
//
// One word at a time. Insert and remove pass dispatch, two memory states, validate and output;
// a dropped or ignored word, a no-op or a rotate that does not move skips the memory states.
// Rotate runs a 31-step remainder unit on step_count mod count, then one link-memory read
// and cursor update per remaining step.
// Reset empties the ring; node memories need no clearing pass.
// A stalled result holds in the output register; the next word is taken after it loads.
module circular_list_cursor_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [clce_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,  // data_value, step_count
  input  logic [clce_pkg::OP_W-1:0]            s_axis_tuser_i,  // op
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [clce_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,  // cursor_value, node_count, is_empty
  output logic [clce_pkg::STATUS_W-1:0]        m_axis_tuser_o   // status
);
  import clce_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  clce_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  clce_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

endmodule
